### design/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the three-button debounce and press
// classifier.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    // Number of buttons polled together
    localparam int unsigned NUM_BUTTONS = 3;

    // Field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned THRESH_W = 16;

    // Stream word widths (packed fields, padded to whole bytes)
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 8;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes (taken from paddr[2])
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    // Reset values of the thresholds
    localparam logic [THRESH_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [THRESH_W-1:0] LONG_PRESS_RST = 16'd1000;

    // Thresholds handed from the register block to each button
    typedef struct packed {
        logic [THRESH_W-1:0] debounce_ms;
        logic [THRESH_W-1:0] long_press_ms;
    } cfg_t;

    // Per-button pulses for one poll
    typedef struct packed {
        logic long_hit;
        logic short_hit;
    } pulse_t;

endpackage

### design/bdlp_cfg.sv
// ----------------------------------------------------------------------------
// bdlp_cfg
// APB-style register block holding the debounce and long-press thresholds.
// ----------------------------------------------------------------------------
module bdlp_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bdlp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bdlp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bdlp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output bdlp_pkg::cfg_t                       cfg
);

    logic [bdlp_pkg::THRESH_W-1:0] debounce_reg;
    logic [bdlp_pkg::THRESH_W-1:0] long_press_reg;
    logic                          wr_en;

    // No wait states
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Threshold registers, word-aligned decode on paddr[2]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= bdlp_pkg::DEBOUNCE_RST;
            long_press_reg <= bdlp_pkg::LONG_PRESS_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == bdlp_pkg::REG_DEBOUNCE)
            begin
                debounce_reg <= pwdata[bdlp_pkg::THRESH_W-1:0];
            end
            else
            begin
                long_press_reg <= pwdata[bdlp_pkg::THRESH_W-1:0];
            end
        end
    end

    // Read mux
    always_comb
    begin
        case (paddr[2])
            bdlp_pkg::REG_DEBOUNCE:
                prdata = {{(bdlp_pkg::APB_DATA_W-bdlp_pkg::THRESH_W){1'b0}}, debounce_reg};
            bdlp_pkg::REG_LONG_PRESS:
                prdata = {{(bdlp_pkg::APB_DATA_W-bdlp_pkg::THRESH_W){1'b0}}, long_press_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.debounce_ms   = debounce_reg;
    assign cfg.long_press_ms = long_press_reg;

endmodule

### design/bdlp_button.sv
// ----------------------------------------------------------------------------
// bdlp_button
// State and next-state logic of one button: arm on a level change, confirm
// or reject after the debounce time, then classify as short or long press.
// ----------------------------------------------------------------------------
module bdlp_button
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            poll_en,
    input  logic [bdlp_pkg::TIME_W-1:0]     now_ms,
    input  logic                            level,
    input  bdlp_pkg::cfg_t                  cfg,
    output bdlp_pkg::pulse_t                pulse
);

    logic                          armed_reg;
    logic                          armed_next;
    logic                          confirmed_reg;
    logic                          confirmed_next;
    logic                          prev_level_reg;
    logic [bdlp_pkg::TIME_W-1:0]   stamp_reg;
    logic [bdlp_pkg::TIME_W-1:0]   stamp_next;

    logic                          arm_now;
    logic                          armed_a;
    logic                          confirmed_b;
    logic                          armed_b;
    logic                          settled;
    logic                          over_long;
    logic                          under_long;
    logic [bdlp_pkg::TIME_W-1:0]   elapsed;

    // Arm on a level change and stamp the time
    assign arm_now    = (level != prev_level_reg) && !armed_reg;
    assign armed_a    = armed_reg || arm_now;
    assign stamp_next = arm_now ? now_ms : stamp_reg;

    // Elapsed time wraps modulo 2^32
    assign elapsed = now_ms - stamp_next;

    // Debounce window passed: confirm if low, drop if high
    assign settled     = (elapsed > {16'd0, cfg.debounce_ms}) && armed_a && !confirmed_reg;
    assign confirmed_b = confirmed_reg || (settled && !level);
    assign armed_b     = armed_a && !(settled && level);

    // Classify; an exact tie with the long threshold gives nothing
    assign over_long  = elapsed > {16'd0, cfg.long_press_ms};
    assign under_long = elapsed < {16'd0, cfg.long_press_ms};

    always_comb
    begin
        pulse.long_hit  = confirmed_b && over_long && !level;
        pulse.short_hit = confirmed_b && !(over_long && !level) && under_long && level;
        confirmed_next  = confirmed_b;
        armed_next      = armed_b;
        if (pulse.long_hit || pulse.short_hit)
        begin
            confirmed_next = 1'b0;
            armed_next     = 1'b0;
        end
    end

    // State update on each processed poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            confirmed_reg  <= 1'b0;
            prev_level_reg <= 1'b0;
            stamp_reg      <= '0;
        end
        else if (poll_en)
        begin
            armed_reg      <= armed_next;
            confirmed_reg  <= confirmed_next;
            prev_level_reg <= level;
            stamp_reg      <= stamp_next;
        end
    end

endmodule

### design/button_debounce_long_press_top.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_top
// Debounce and short/long press detection for three pulled-up buttons.
// Each input word is one poll: a free-running millisecond time and the raw
// levels of the main, first and second control buttons (0 = pressed). Each
// poll yields one output word with a one-poll short and long pulse per
// button. One poll is taken every clock cycle while the result side is not
// stalled. A poll is held in the input register, and its result word is
// registered in the result register and offered on the master side from
// there. The per-button state closes its loop combinationally between the
// two registers, and a stalled result word holds the input. Thresholds are
// set over the APB port (byte address 0: debounce_ms, 4: long_press_ms) and
// should only be changed while no poll is in flight.
// ----------------------------------------------------------------------------
module button_debounce_long_press_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Poll words
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [31:0] now_ms, [32] main_level, [33] ctrl1_level, [34] ctrl2_level
    input  logic [bdlp_pkg::IN_DATA_W-1:0]       s_tdata,
    // Result words
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] main_short, [1] main_long, [2] ctrl1_short, [3] ctrl1_long,
    // [4] ctrl2_short, [5] ctrl2_long
    output logic [bdlp_pkg::OUT_DATA_W-1:0]      m_tdata,
    // Configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bdlp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bdlp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bdlp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    bdlp_pkg::cfg_t                          cfg;
    bdlp_pkg::pulse_t [bdlp_pkg::NUM_BUTTONS-1:0] pulses;

    logic                                    in_valid_reg;
    logic [bdlp_pkg::TIME_W-1:0]             in_now_reg;
    logic [bdlp_pkg::NUM_BUTTONS-1:0]        in_level_reg;
    logic                                    out_valid_reg;
    logic [2*bdlp_pkg::NUM_BUTTONS-1:0]      out_pulse_reg;
    logic [2*bdlp_pkg::NUM_BUTTONS-1:0]      out_pulse_next;
    logic                                    advance;

    // Register block
    bdlp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: the held poll moves on whenever the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_now_reg   <= s_tdata[bdlp_pkg::TIME_W-1:0];
            in_level_reg <= s_tdata[bdlp_pkg::TIME_W +: bdlp_pkg::NUM_BUTTONS];
        end
    end

    // One state machine per button
    for (genvar b = 0; b < bdlp_pkg::NUM_BUTTONS; b++)
    begin : g_btn
        bdlp_button u_btn
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .poll_en (advance),
            .now_ms  (in_now_reg),
            .level   (in_level_reg[b]),
            .cfg     (cfg),
            .pulse   (pulses[b])
        );
        assign out_pulse_next[2*b]   = pulses[b].short_hit;
        assign out_pulse_next[2*b+1] = pulses[b].long_hit;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pulse_reg <= out_pulse_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bdlp_pkg::OUT_DATA_W-2*bdlp_pkg::NUM_BUTTONS){1'b0}}, out_pulse_reg};

    // A button never pulses short and long in the same word
    a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && !(m_tdata[2] && m_tdata[3])
                     && !(m_tdata[4] && m_tdata[5]))
        else $error("short and long pulse together");

    // A processed poll always lands in the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed poll lost");

    // Empty input register always takes a word
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

    // A stalled result keeps the held poll waiting
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !advance)
        else $error("poll processed over a stalled result");

endmodule
